/* rtl/bs_pkg.sv */
// Shared constants, element type, controller states and command bundle for the bitonic sorter.
package bs_pkg;

   localparam int NUM_ELEMENTS  = 16;
   localparam int ELEMENT_WIDTH = 32;
   localparam int IDX_W         = $clog2(NUM_ELEMENTS);
   localparam int STG_W         = $clog2(IDX_W + 1);

   typedef logic signed [ELEMENT_WIDTH-1:0] elem_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_EMIT
   } bs_state_type;

   typedef struct packed {
      logic             shift;    // move every element down one place, new value at the top
      logic             stage;    // apply one compare-exchange stage of the network
      logic [STG_W-1:0] blk_idx;  // log2 of the current block size
      logic [STG_W-1:0] stp_idx;  // log2 of the current partner distance
   } bs_cmd_type;

endpackage

/* rtl/bs_if.sv */
// Valid/ready channel interfaces for the sorter's input values and sorted results.
interface bs_req_if;
   logic               valid;
   logic               ready;
   bs_pkg::elem_type   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface bs_rsp_if;
   logic               valid;
   logic               ready;
   bs_pkg::elem_type   sorted_value;
   logic               last_out;

   modport source (output valid, output sorted_value, output last_out, input ready);
   modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

/* rtl/bitonic_sorter_unit.sv */
// Top level of the bitonic sorter: controller, element row and channel hookup.
//
// Bitonic sorter for batches of NUM_ELEMENTS (16) signed 32-bit values.
// Values arrive one per req_ch beat and enter a 16-entry shift line, the
// first value of a batch ending in place 0. While a batch loads, req_ch.ready
// is high and one value is taken per cycle while req_ch.valid is high. When
// the sixteenth value lands, the block stops taking input and runs the
// network: one compare-exchange stage per cycle over all pairs at once,
// log2(N)*(log2(N)+1)/2 stages in all. It then emits the batch in ascending
// signed order on rsp_ch, one beat per cycle while the sink is ready, with
// last_out on the final beat; input is taken again once that beat is gone.
// The single shift line both loads and drains the batch, one element per
// cycle while its side keeps up, so a new batch is not taken while one is
// still in the row. Equal values are never swapped. No clearing pass follows
// reset.
module bitonic_sorter_unit (
   input  logic     clock,
   input  logic     reset,
   bs_req_if.sink   req_ch,
   bs_rsp_if.source rsp_ch
);
   import bs_pkg::*;

   bs_cmd_type cmd;
   elem_type   head;
   logic       last;

   // sequence load, network stages and drain
   bs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_last  (last),
      .cmd       (cmd)
   );

   // hold the batch, shift it in and out, apply network stages
   bs_dpath u_dpath (
      .clock (clock),
      .cmd   (cmd),
      .din   (req_ch.value),
      .dout  (head)
   );

   // place 0 of the row is the next beat to leave
   assign rsp_ch.sorted_value = head;
   assign rsp_ch.last_out     = last;

endmodule

/* rtl/bs_ctrl.sv */
// Sequencer for the sorter: load count, network stage counters and emit count.
module bs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_last,
   output bs_pkg::bs_cmd_type cmd
);
   import bs_pkg::*;

   bs_state_type     state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [STG_W-1:0] blk_ff, blk_in;
   logic [STG_W-1:0] stp_ff, stp_in;

   localparam logic [IDX_W-1:0] CntLast = IDX_W'(NUM_ELEMENTS - 1);
   localparam logic [STG_W-1:0] BlkLast = STG_W'(IDX_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         blk_ff   <= STG_W'(1);
         stp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         blk_ff   <= blk_in;
         stp_ff   <= stp_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      blk_in      = blk_ff;
      stp_in      = stp_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      rsp_last    = 1'b0;
      cmd.shift   = 1'b0;
      cmd.stage   = 1'b0;
      cmd.blk_idx = blk_ff;
      cmd.stp_idx = stp_ff;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.shift = 1'b1;
               cnt_in    = cnt_ff + IDX_W'(1);
               if (cnt_ff == CntLast) begin
                  cnt_in   = '0;
                  blk_in   = STG_W'(1);
                  stp_in   = '0;
                  state_in = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            cmd.stage = 1'b1;
            if (stp_ff == '0) begin
               if (blk_ff == BlkLast) begin
                  state_in = ST_EMIT;
               end else begin
                  blk_in = blk_ff + STG_W'(1);
                  stp_in = blk_ff;
               end
            end else begin
               stp_in = stp_ff - STG_W'(1);
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = (cnt_ff == CntLast);
            if (rsp_ready) begin
               cmd.shift = 1'b1;
               cnt_in    = cnt_ff + IDX_W'(1);
               if (cnt_ff == CntLast) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
            cnt_in   = '0;
         end
      endcase
   end

endmodule

/* rtl/bs_dpath.sv */
// Element row of the sorter: shift line for load and emit, compare-exchange lanes for the network.
module bs_dpath (
   input  logic               clock,
   input  bs_pkg::bs_cmd_type cmd,
   input  bs_pkg::elem_type   din,
   output bs_pkg::elem_type   dout
);
   import bs_pkg::*;

   elem_type elem_ff [NUM_ELEMENTS];
   elem_type elem_in [NUM_ELEMENTS];

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   always_comb begin
      elem_type own;
      elem_type partner;
      elem_type lo_val;
      elem_type hi_val;
      logic     is_lower;
      logic     desc;
      logic     swap;
      elem_in  = elem_ff;
      own      = '0;
      partner  = '0;
      lo_val   = '0;
      hi_val   = '0;
      is_lower = 1'b0;
      desc     = 1'b0;
      swap     = 1'b0;
      if (cmd.shift) begin
         for (int i = 0; i < NUM_ELEMENTS - 1; i++) begin
            elem_in[i] = elem_ff[i+1];
         end
         elem_in[NUM_ELEMENTS-1] = din;
      end else if (cmd.stage) begin
         for (int i = 0; i < NUM_ELEMENTS; i++) begin
            own      = elem_ff[i];
            partner  = own;
            is_lower = 1'b1;
            desc     = 1'b0;
            for (int k = 0; k < IDX_W; k++) begin
               if (cmd.stp_idx == STG_W'(k)) begin
                  partner  = elem_ff[IDX_W'(i ^ (1 << k))];
                  is_lower = (((i >> k) & 1) == 0);
               end
            end
            // pair order is descending where the block bit of the index is set
            for (int k = 1; k < IDX_W; k++) begin
               if (cmd.blk_idx == STG_W'(k)) begin
                  desc = (((i >> k) & 1) != 0);
               end
            end
            lo_val = is_lower ? own : partner;
            hi_val = is_lower ? partner : own;
            swap   = desc ? (lo_val < hi_val) : (lo_val > hi_val);
            elem_in[i] = swap ? partner : own;
         end
      end
   end

   assign dout = elem_ff[0];

endmodule
